// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/fcgi_pkg.sv =====
// Shared codes and types for the FastCGI record deframer.
package fcgi_pkg;

   // Event codes on the result channel
   localparam logic [2:0] EV_CONSUMED = 3'd0;
   localparam logic [2:0] EV_PAYLOAD  = 3'd1;
   localparam logic [2:0] EV_BEGIN    = 3'd2;
   localparam logic [2:0] EV_EMPTY    = 3'd3;
   localparam logic [2:0] EV_ERROR    = 3'd4;

   // Header field values
   localparam logic [7:0]  VERSION_ONE = 8'd1;
   localparam logic [7:0]  KIND_LIMIT  = 8'd11;
   localparam logic [3:0]  KIND_BEGIN  = 4'd1;
   localparam logic [3:0]  KIND_PARAMS = 4'd4;
   localparam logic [3:0]  KIND_STDIN  = 4'd5;
   localparam logic [15:0] ROLE_RESP   = 16'd1;

   // One result item
   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] payload;
      logic [3:0] record_kind;
      logic [7:0] request_flags;
      logic       record_done;
   } fcgi_rsp_type;

endpackage

// ===== rtl/core/fastcgi_record_deframer.sv =====
// Top level of the FastCGI record deframer: parser and two-entry result buffer.
// Takes one stream byte per clock while req_stall is low and returns exactly
// one result item for every byte. The parser updates its header state once per
// accepted byte, so a new byte can be accepted every clock while req_stall is low.
// Results go to a two-entry buffer (output register plus skid register); req_stall is
// registered and rises only when both entries hold an item, so a full rate of
// one item per clock is kept as long as rsp_stall stays low. Errors (bad
// version, type or role, or content on an unsupported type) are sticky until
// reset.
module fastcgi_record_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_payload,
   output logic [3:0] rsp_record_kind,
   output logic [7:0] rsp_request_flags,
   output logic       rsp_record_done
);
   import fcgi_pkg::*;

   fcgi_rsp_type step_rsp;
   fcgi_rsp_type out_ff;
   fcgi_rsp_type skid_ff;
   logic         out_valid_ff;
   logic         skid_valid_ff;
   logic         accept;
   logic         take;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   fcgi_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .result    (step_rsp)
   );

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload moves without reset
   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_ff <= skid_valid_ff ? skid_ff : step_rsp;
      end else if (accept) begin
         skid_ff <= step_rsp;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = out_ff.event_res;
   assign rsp_payload       = out_ff.payload;
   assign rsp_record_kind   = out_ff.record_kind;
   assign rsp_request_flags = out_ff.request_flags;
   assign rsp_record_done   = out_ff.record_done;

endmodule

// ===== rtl/core/fcgi_parser.sv =====
// Record parser: phase state, header fields and the per-byte result.
module fcgi_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   output fcgi_pkg::fcgi_rsp_type result
);
   import fcgi_pkg::*;

   typedef enum logic [4:0] {
      PH_VERSION = 5'd0,
      PH_TYPE    = 5'd1,
      PH_RID1    = 5'd2,
      PH_RID2    = 5'd3,
      PH_CLEN1   = 5'd4,
      PH_CLEN2   = 5'd5,
      PH_PLEN    = 5'd6,
      PH_RSVD    = 5'd7,
      PH_ROLE1   = 5'd8,
      PH_ROLE2   = 5'd9,
      PH_FLAGS   = 5'd10,
      PH_BRES1   = 5'd11,
      PH_BRES2   = 5'd12,
      PH_BRES3   = 5'd13,
      PH_BRES4   = 5'd14,
      PH_BRES5   = 5'd15,
      PH_DATA    = 5'd16,
      PH_PAD     = 5'd17,
      PH_ERROR   = 5'd18
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  kind_ff, kind_in;
   logic [15:0] content_ff, content_in;
   logic [7:0]  padding_ff, padding_in;
   logic [7:0]  role_high_ff, role_high_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] content_dec;
   logic [7:0]  padding_dec;
   logic [2:0]  ev;
   logic [7:0]  pay;
   logic        done;

   assign content_dec = content_ff - 16'd1;
   assign padding_dec = padding_ff - 8'd1;

   // Next state and result for the byte at the input
   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      content_in   = content_ff;
      padding_in   = padding_ff;
      role_high_in = role_high_ff;
      flags_in     = flags_ff;
      ev           = EV_CONSUMED;
      pay          = 8'd0;
      done         = 1'b0;
      unique case (phase_ff)
         PH_VERSION: begin
            if (data_byte != VERSION_ONE) begin
               phase_in = PH_ERROR;
               ev       = EV_ERROR;
            end else begin
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (data_byte >= KIND_LIMIT) begin
               phase_in = PH_ERROR;
               ev       = EV_ERROR;
            end else begin
               kind_in  = data_byte[3:0];
               phase_in = PH_RID1;
            end
         end
         PH_RID1: phase_in = PH_RID2;
         PH_RID2: phase_in = PH_CLEN1;
         PH_CLEN1: begin
            content_in = {data_byte, 8'd0};
            phase_in   = PH_CLEN2;
         end
         PH_CLEN2: begin
            content_in = {content_ff[15:8], data_byte};
            phase_in   = PH_PLEN;
         end
         PH_PLEN: begin
            padding_in = data_byte;
            phase_in   = PH_RSVD;
         end
         PH_RSVD: begin
            if (content_ff != 16'd0) begin
               priority if (kind_ff == KIND_BEGIN) begin
                  phase_in = PH_ROLE1;
               end else if (kind_ff == KIND_PARAMS || kind_ff == KIND_STDIN) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_ERROR;
                  ev       = EV_ERROR;
               end
            end else begin
               // empty record: skip its padding, or end at once
               ev       = EV_EMPTY;
               done     = (padding_ff == 8'd0);
               phase_in = done ? PH_VERSION : PH_PAD;
            end
         end
         PH_ROLE1: begin
            content_in   = content_dec;
            role_high_in = data_byte;
            phase_in     = PH_ROLE2;
         end
         PH_ROLE2: begin
            content_in = content_dec;
            if ({role_high_ff, data_byte} != ROLE_RESP) begin
               phase_in = PH_ERROR;
               ev       = EV_ERROR;
            end else begin
               phase_in = PH_FLAGS;
            end
         end
         PH_FLAGS: begin
            content_in = content_dec;
            flags_in   = data_byte;
            phase_in   = PH_BRES1;
         end
         PH_BRES1: begin
            content_in = content_dec;
            phase_in   = PH_BRES2;
         end
         PH_BRES2: begin
            content_in = content_dec;
            phase_in   = PH_BRES3;
         end
         PH_BRES3: begin
            content_in = content_dec;
            phase_in   = PH_BRES4;
         end
         PH_BRES4: begin
            content_in = content_dec;
            phase_in   = PH_BRES5;
         end
         PH_BRES5: begin
            content_in = content_dec;
            ev         = EV_BEGIN;
            done       = (padding_ff == 8'd0);
            phase_in   = done ? PH_VERSION : PH_PAD;
         end
         PH_DATA: begin
            ev         = EV_PAYLOAD;
            pay        = data_byte;
            content_in = content_dec;
            if (content_dec == 16'd0) begin
               done     = (padding_ff == 8'd0);
               phase_in = done ? PH_VERSION : PH_PAD;
            end
         end
         PH_PAD: begin
            padding_in = padding_dec;
            if (padding_dec == 8'd0) begin
               phase_in = PH_VERSION;
               done     = 1'b1;
            end
         end
         PH_ERROR: begin
            ev = EV_ERROR;
         end
         default: begin
            phase_in = PH_ERROR;
            ev       = EV_ERROR;
         end
      endcase
   end

   // Result reflects held fields after this byte
   assign result.event_res     = ev;
   assign result.payload       = pay;
   assign result.record_kind   = kind_in;
   assign result.request_flags = flags_in;
   assign result.record_done   = done;

   // State update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VERSION;
         kind_ff      <= 4'd0;
         content_ff   <= 16'd0;
         padding_ff   <= 8'd0;
         role_high_ff <= 8'd0;
         flags_ff     <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         content_ff   <= content_in;
         padding_ff   <= padding_in;
         role_high_ff <= role_high_in;
         flags_ff     <= flags_in;
      end
   end

endmodule

// ===== rtl/core/fcgi_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
`include "assert_macros.svh"

module fcgi_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_event_res,
   input logic [7:0] rsp_payload,
   input logic [3:0] rsp_record_kind,
   input logic [7:0] rsp_request_flags,
   input logic       rsp_record_done
);
   import fcgi_pkg::*;

   logic        rsp_take;
   logic        rsp_waits;
   logic        req_waits;
   logic        rsp_is_error;
   logic        rsp_no_payload;
   logic [23:0] rsp_fields;

   assign rsp_take       = rsp_valid && !rsp_stall;
   assign rsp_waits      = rsp_valid && rsp_stall;
   assign req_waits      = req_valid && req_stall;
   assign rsp_is_error   = rsp_valid && (rsp_event_res == EV_ERROR);
   assign rsp_no_payload = rsp_valid && (rsp_event_res != EV_PAYLOAD);
   assign rsp_fields     = {rsp_event_res, rsp_payload, rsp_record_kind, rsp_request_flags,
                            rsp_record_done};

   // payload is zero unless the item carries a content byte
   `ASSERT_SAME(a_payload_zero, clock, reset, rsp_no_payload, rsp_payload == 8'd0)
   // an error never ends a record
   `ASSERT_SAME(a_error_not_done, clock, reset, rsp_is_error, !rsp_record_done)
   // error is sticky: the next item shown is an error too
   `ASSERT_NEXT(a_error_sticky, clock, reset, rsp_take && rsp_is_error, !rsp_valid || rsp_is_error)
   // a stalled result holds all of its fields
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waits, rsp_valid && $stable(rsp_fields))
   // a stalled input byte stays on the port
   `ASSERT_NEXT(a_req_hold, clock, reset, req_waits, req_valid && $stable(req_data_byte))

endmodule

bind fastcgi_record_deframer fcgi_checker u_fcgi_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_data_byte     (req_data_byte),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_res     (rsp_event_res),
   .rsp_payload       (rsp_payload),
   .rsp_record_kind   (rsp_record_kind),
   .rsp_request_flags (rsp_request_flags),
   .rsp_record_done   (rsp_record_done)
);
